>>> design/pep_pkg.sv
// Shared constants for the plane-equation pipeline.
// No dependencies; every other design file imports this package.
package pep_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 14;

    // Normalized magnitudes have their leading one at bit NORM_W-1.
    localparam int NORM_W  = 31;
    localparam int SQ_W    = 2 * NORM_W + 2;
    localparam int ROOT_W  = SQ_W / 2;
    localparam int PT_FRAC = 8;

endpackage

>>> design/plane_equation_from_points_top.sv
// Plane through three points: unit normal and plane offset, fully pipelined.
// Depends on pep_pkg, pep_cross, pep_norm, pep_sqrt, pep_div and pep_plane.

// Takes one triangle (three Q8.8 points, counter-clockwise) per transaction and returns
// one result per transaction: the unit normal in Q2.14 and the offset d = -(n . P3) in
// Q10.14, or zeros with degenerate set when the points are collinear. One transaction
// is accepted every cycle while the output is not stalled. A transaction passes in order
// through the cross product, normalization and the sum of squares, the bit-per-stage
// square root, the three bit-per-stage dividers and the dot product and output register.
// Results leave in order; a stall fills the empty stages before it holds the input.
module plane_equation_from_points_top
    import pep_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic signed [COORD_BITS-1:0] p1_x,
    input  logic signed [COORD_BITS-1:0] p1_y,
    input  logic signed [COORD_BITS-1:0] p1_z,
    input  logic signed [COORD_BITS-1:0] p2_x,
    input  logic signed [COORD_BITS-1:0] p2_y,
    input  logic signed [COORD_BITS-1:0] p2_z,
    input  logic signed [COORD_BITS-1:0] p3_x,
    input  logic signed [COORD_BITS-1:0] p3_y,
    input  logic signed [COORD_BITS-1:0] p3_z,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic signed [FRAC_BITS+1:0]  normal_x,
    output logic signed [FRAC_BITS+1:0]  normal_y,
    output logic signed [FRAC_BITS+1:0]  normal_z,
    output logic signed [FRAC_BITS+9:0]  plane_offset,
    output logic                         degenerate
);

    localparam int CB   = COORD_BITS;
    localparam int CW   = 2 * CB + 3;
    localparam int NW   = FRAC_BITS + 2;
    localparam int QB   = FRAC_BITS + 1;
    localparam int DV_W = 3 * CB + 4;
    localparam int SQ_SIDE_W = DV_W + 3 * NORM_W;

    localparam logic signed [NW-1:0] POS_UNIT = NW'(1) << FRAC_BITS;
    localparam logic signed [NW-1:0] NEG_UNIT = -POS_UNIT;

    logic signed [CB-1:0] p1 [3];
    logic signed [CB-1:0] p2 [3];
    logic signed [CB-1:0] p3 [3];

    logic                 cr_ready, cr_valid;
    logic signed [CW-1:0] cr_c [3];
    logic signed [CB-1:0] cr_p3 [3];

    logic                 nm_ready, nm_valid;
    logic [SQ_W-1:0]      nm_s;
    logic [NORM_W-1:0]    nm_m [3];
    logic [2:0]           nm_sgn;
    logic                 nm_zero;
    logic signed [CB-1:0] nm_p3 [3];

    logic                 sq_ready, sq_valid;
    logic [SQ_SIDE_W-1:0] sq_side_in, sq_side_out;
    logic [ROOT_W-1:0]    sq_root;
    logic [NORM_W-1:0]    sq_m [3];

    logic                 dv_ready, dv_valid;
    logic [QB-1:0]        dv_q [3];
    logic [DV_W-1:0]      dv_side;
    logic signed [CB-1:0] dv_p3 [3];

    logic                 pl_ready;
    logic signed [NW-1:0] pl_n [3];

    assign p1 = '{p1_x, p1_y, p1_z};
    assign p2 = '{p2_x, p2_y, p2_z};
    assign p3 = '{p3_x, p3_y, p3_z};

    pep_cross #(.CB(CB)) u_cross (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (cr_ready),
        .p1        (p1),
        .p2        (p2),
        .p3        (p3),
        .out_valid (cr_valid),
        .out_ready (nm_ready),
        .c         (cr_c),
        .p3_out    (cr_p3)
    );

    pep_norm #(.CB(CB)) u_norm (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cr_valid),
        .in_ready  (nm_ready),
        .c         (cr_c),
        .p3        (cr_p3),
        .out_valid (nm_valid),
        .out_ready (sq_ready),
        .s         (nm_s),
        .m         (nm_m),
        .sgn       (nm_sgn),
        .zero      (nm_zero),
        .p3_out    (nm_p3)
    );

    // Side data through the root stages: third point, signs, degenerate flag, magnitudes.
    assign sq_side_in = {nm_p3[0], nm_p3[1], nm_p3[2], nm_sgn, nm_zero,
                         nm_m[0], nm_m[1], nm_m[2]};

    pep_sqrt #(.SIDE_W(SQ_SIDE_W)) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (nm_valid),
        .in_ready  (sq_ready),
        .s         (nm_s),
        .side      (sq_side_in),
        .out_valid (sq_valid),
        .out_ready (dv_ready),
        .root      (sq_root),
        .side_out  (sq_side_out)
    );

    assign sq_m[0] = sq_side_out[3*NORM_W-1 -: NORM_W];
    assign sq_m[1] = sq_side_out[2*NORM_W-1 -: NORM_W];
    assign sq_m[2] = sq_side_out[NORM_W-1:0];

    pep_div #(.F(FRAC_BITS), .SIDE_W(DV_W)) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sq_valid),
        .in_ready  (dv_ready),
        .m         (sq_m),
        .r         (sq_root),
        .side      (sq_side_out[SQ_SIDE_W-1 -: DV_W]),
        .out_valid (dv_valid),
        .out_ready (pl_ready),
        .q         (dv_q),
        .side_out  (dv_side)
    );

    assign dv_p3[0] = dv_side[DV_W-1 -: CB];
    assign dv_p3[1] = dv_side[DV_W-CB-1 -: CB];
    assign dv_p3[2] = dv_side[DV_W-2*CB-1 -: CB];

    pep_plane #(.CB(CB), .F(FRAC_BITS)) u_plane (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (dv_valid),
        .in_ready  (pl_ready),
        .q         (dv_q),
        .sgn       (dv_side[3:1]),
        .zero      (dv_side[0]),
        .p3        (dv_p3),
        .out_valid (out_valid),
        .out_ready (!out_stall),
        .n         (pl_n),
        .d         (plane_offset),
        .degen     (degenerate)
    );

    assign in_stall = !cr_ready;
    assign normal_x = pl_n[0];
    assign normal_y = pl_n[1];
    assign normal_z = pl_n[2];

    a_full_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input held off while the pipeline could still advance");

    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && degenerate |->
            normal_x == '0 && normal_y == '0 && normal_z == '0 && plane_offset == '0)
        else $error("degenerate transaction with nonzero result");

    a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !degenerate |->
            normal_x <= POS_UNIT && normal_x >= NEG_UNIT &&
            normal_y <= POS_UNIT && normal_y >= NEG_UNIT &&
            normal_z <= POS_UNIT && normal_z >= NEG_UNIT)
        else $error("normal component beyond one");

endmodule

>>> design/pep_cross.sv
// Edge vectors and cross product, three pipeline stages.
// Depends on pep_pkg.
module pep_cross
    import pep_pkg::*;
#(
    parameter int CB = COORD_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic signed [CB-1:0]  p1 [3],
    input  logic signed [CB-1:0]  p2 [3],
    input  logic signed [CB-1:0]  p3 [3],
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic signed [2*CB+2:0] c [3],
    output logic signed [CB-1:0]  p3_out [3]
);

    localparam int UW = CB + 1;
    localparam int PW = 2 * UW;
    localparam int CW = PW + 1;
    localparam int NS = 3;

    logic [NS-1:0] v_reg;
    logic [NS:0]   en;

    logic signed [UW-1:0] u_reg [3];
    logic signed [UW-1:0] w_reg [3];
    logic signed [PW-1:0] prod_reg [6];
    logic signed [CW-1:0] c_reg [3];
    logic signed [CB-1:0] p3_reg [NS][3];

    always_comb
    begin
        en[NS] = out_ready;
        for (int k = NS - 1; k >= 0; k--)
        begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end

    assign in_ready  = en[0];
    assign out_valid = v_reg[NS-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                v_reg[0] <= in_valid;
            end
            for (int k = 1; k < NS; k++)
            begin
                if (en[k])
                begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            for (int j = 0; j < 3; j++)
            begin
                u_reg[j]     <= p2[j] - p1[j];
                w_reg[j]     <= p3[j] - p1[j];
                p3_reg[0][j] <= p3[j];
            end
        end
        if (en[1])
        begin
            prod_reg[0] <= u_reg[1] * w_reg[2];
            prod_reg[1] <= w_reg[1] * u_reg[2];
            prod_reg[2] <= w_reg[0] * u_reg[2];
            prod_reg[3] <= u_reg[0] * w_reg[2];
            prod_reg[4] <= u_reg[0] * w_reg[1];
            prod_reg[5] <= w_reg[0] * u_reg[1];
            p3_reg[1]   <= p3_reg[0];
        end
        if (en[2])
        begin
            for (int j = 0; j < 3; j++)
            begin
                c_reg[j] <= prod_reg[2*j] - prod_reg[2*j+1];
            end
            p3_reg[2] <= p3_reg[1];
        end
    end

    assign c      = c_reg;
    assign p3_out = p3_reg[NS-1];

endmodule

>>> design/pep_norm.sv
// Magnitude, common normalizing shift and sum of squares, five stages.
// Depends on pep_pkg.
module pep_norm
    import pep_pkg::*;
#(
    parameter int CB = COORD_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic signed [2*CB+2:0] c [3],
    input  logic signed [CB-1:0]   p3 [3],
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [SQ_W-1:0]        s,
    output logic [NORM_W-1:0]      m [3],
    output logic [2:0]             sgn,
    output logic                   zero,
    output logic signed [CB-1:0]   p3_out [3]
);

    localparam int CW  = 2 * CB + 3;
    localparam int MW  = CW - 1;
    localparam int PSW = $clog2(MW);
    localparam int EW  = MW + NORM_W - 1;
    localparam int NS  = 5;

    logic [NS-1:0] v_reg;
    logic [NS:0]   en;

    logic [MW-1:0]        mag_reg [2][3];
    logic [PSW-1:0]       pos_reg;
    logic [NORM_W-1:0]    m_reg [2:4][3];
    logic [2*NORM_W-1:0]  sq_reg [3];
    logic [SQ_W-1:0]      s_reg;
    logic [2:0]           sgn_reg [NS];
    logic                 zero_reg [1:4];
    logic signed [CB-1:0] p3_reg [NS][3];

    logic [MW-1:0]  orv;
    logic [PSW-1:0] pos_next;
    logic [EW-1:0]  ext [3];

    always_comb
    begin
        en[NS] = out_ready;
        for (int k = NS - 1; k >= 0; k--)
        begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end

    assign in_ready  = en[0];
    assign out_valid = v_reg[NS-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                v_reg[0] <= in_valid;
            end
            for (int k = 1; k < NS; k++)
            begin
                if (en[k])
                begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    // The leading one of the OR of the magnitudes is the leading one of the largest.
    always_comb
    begin
        orv = mag_reg[0][0] | mag_reg[0][1] | mag_reg[0][2];
        pos_next = '0;
        for (int i = 0; i < MW; i++)
        begin
            if (orv[i])
            begin
                pos_next = PSW'(i);
            end
        end
        for (int j = 0; j < 3; j++)
        begin
            ext[j] = {mag_reg[1][j], {(NORM_W-1){1'b0}}} >> pos_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            for (int j = 0; j < 3; j++)
            begin
                mag_reg[0][j] <= MW'(c[j] < 0 ? -c[j] : c[j]);
                sgn_reg[0][j] <= c[j] < 0;
            end
            p3_reg[0] <= p3;
        end
        if (en[1])
        begin
            mag_reg[1]  <= mag_reg[0];
            pos_reg     <= pos_next;
            zero_reg[1] <= (orv == '0);
            sgn_reg[1]  <= sgn_reg[0];
            p3_reg[1]   <= p3_reg[0];
        end
        if (en[2])
        begin
            for (int j = 0; j < 3; j++)
            begin
                m_reg[2][j] <= ext[j][NORM_W-1:0];
            end
            zero_reg[2] <= zero_reg[1];
            sgn_reg[2]  <= sgn_reg[1];
            p3_reg[2]   <= p3_reg[1];
        end
        if (en[3])
        begin
            for (int j = 0; j < 3; j++)
            begin
                sq_reg[j] <= m_reg[2][j] * m_reg[2][j];
            end
            m_reg[3]    <= m_reg[2];
            zero_reg[3] <= zero_reg[2];
            sgn_reg[3]  <= sgn_reg[2];
            p3_reg[3]   <= p3_reg[2];
        end
        if (en[4])
        begin
            s_reg       <= SQ_W'(sq_reg[0]) + SQ_W'(sq_reg[1]) + SQ_W'(sq_reg[2]);
            m_reg[4]    <= m_reg[3];
            zero_reg[4] <= zero_reg[3];
            sgn_reg[4]  <= sgn_reg[3];
            p3_reg[4]   <= p3_reg[3];
        end
    end

    assign s      = s_reg;
    assign m      = m_reg[4];
    assign sgn    = sgn_reg[NS-1];
    assign zero   = zero_reg[4];
    assign p3_out = p3_reg[NS-1];

    a_norm_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !zero |-> ((m[0] | m[1] | m[2]) >> (NORM_W - 1)) == NORM_W'(1))
        else $error("normalized magnitudes out of range");

endmodule

>>> design/pep_sqrt.sv
// Pipelined digit-by-digit integer square root, one root bit per stage.
// Depends on pep_pkg.
module pep_sqrt
    import pep_pkg::*;
#(
    parameter int SIDE_W = 8
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [SQ_W-1:0]   s,
    input  logic [SIDE_W-1:0] side,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [ROOT_W-1:0] root,
    output logic [SIDE_W-1:0] side_out
);

    localparam int NS  = ROOT_W;
    localparam int RMW = ROOT_W + 2;

    logic [NS-1:0] v_reg;
    logic [NS:0]   en;

    logic [SQ_W-1:0]   s_reg    [NS];
    logic [RMW-1:0]    rem_reg  [NS];
    logic [ROOT_W-1:0] root_reg [NS];
    logic [SIDE_W-1:0] side_reg [NS];

    logic [SQ_W-1:0]   s_src    [NS];
    logic [RMW-1:0]    rem_src  [NS];
    logic [ROOT_W-1:0] root_src [NS];
    logic [SIDE_W-1:0] side_src [NS];

    logic [SQ_W-1:0]   s_nx    [NS];
    logic [RMW-1:0]    rem_nx  [NS];
    logic [ROOT_W-1:0] root_nx [NS];

    always_comb
    begin
        en[NS] = out_ready;
        for (int k = NS - 1; k >= 0; k--)
        begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end

    assign in_ready  = en[0];
    assign out_valid = v_reg[NS-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                v_reg[0] <= in_valid;
            end
            for (int k = 1; k < NS; k++)
            begin
                if (en[k])
                begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    always_comb
    begin
        s_src[0]    = s;
        rem_src[0]  = '0;
        root_src[0] = '0;
        side_src[0] = side;
        for (int k = 1; k < NS; k++)
        begin
            s_src[k]    = s_reg[k-1];
            rem_src[k]  = rem_reg[k-1];
            root_src[k] = root_reg[k-1];
            side_src[k] = side_reg[k-1];
        end
    end

    for (genvar k = 0; k < NS; k++)
    begin : g_step
        logic [RMW+1:0] cur;
        logic [RMW+1:0] trial;

        always_comb
        begin
            cur   = {rem_src[k], s_src[k][SQ_W-1 -: 2]};
            trial = (RMW+2)'({root_src[k], 2'b01});
            s_nx[k] = s_src[k] << 2;
            if (cur >= trial)
            begin
                rem_nx[k]  = RMW'(cur - trial);
                root_nx[k] = {root_src[k][ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_nx[k]  = RMW'(cur);
                root_nx[k] = {root_src[k][ROOT_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < NS; k++)
        begin
            if (en[k])
            begin
                s_reg[k]    <= s_nx[k];
                rem_reg[k]  <= rem_nx[k];
                root_reg[k] <= root_nx[k];
                side_reg[k] <= side_src[k];
            end
        end
    end

    assign root     = root_reg[NS-1];
    assign side_out = side_reg[NS-1];

endmodule

>>> design/pep_div.sv
// Three-lane pipelined restoring divider with rounding bias, one quotient bit per stage.
// Depends on pep_pkg.
module pep_div
    import pep_pkg::*;
#(
    parameter int F      = FRAC_BITS_DEF,
    parameter int SIDE_W = 8
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [NORM_W-1:0] m [3],
    input  logic [ROOT_W-1:0] r,
    input  logic [SIDE_W-1:0] side,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [F:0]        q [3],
    output logic [SIDE_W-1:0] side_out
);

    localparam int QB = F + 1;
    localparam int NB = NORM_W + F + 1;
    localparam int NS = QB + 1;

    logic [NS-1:0] v_reg;
    logic [NS:0]   en;

    logic [ROOT_W-1:0] rem_reg [NS][3];
    logic [QB-1:0]     low_reg [NS][3];
    logic [QB-1:0]     q_reg   [NS][3];
    logic [ROOT_W-1:0] r_reg   [NS];
    logic [SIDE_W-1:0] side_reg [NS];

    logic [ROOT_W-1:0] rem_nx [NS][3];
    logic [QB-1:0]     low_nx [NS][3];
    logic [QB-1:0]     q_nx   [NS][3];
    logic [ROOT_W-1:0] r_nx   [NS];
    logic [SIDE_W-1:0] side_nx [NS];

    always_comb
    begin
        en[NS] = out_ready;
        for (int k = NS - 1; k >= 0; k--)
        begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end

    assign in_ready  = en[0];
    assign out_valid = v_reg[NS-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                v_reg[0] <= in_valid;
            end
            for (int k = 1; k < NS; k++)
            begin
                if (en[k])
                begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    // Numerator m * 2^F + floor(r/2); the quotient never exceeds 2^F, so
    // the upper bits already sit below the divisor.
    always_comb
    begin
        logic [NB-1:0] num;
        for (int j = 0; j < 3; j++)
        begin
            num = (NB'(m[j]) << F) + NB'(r >> 1);
            rem_nx[0][j] = ROOT_W'(num[NB-1:QB]);
            low_nx[0][j] = num[QB-1:0];
            q_nx[0][j]   = '0;
        end
        r_nx[0]    = r;
        side_nx[0] = side;
    end

    for (genvar k = 1; k < NS; k++)
    begin : g_step
        always_comb
        begin
            logic [ROOT_W:0] cur;
            for (int j = 0; j < 3; j++)
            begin
                cur = {rem_reg[k-1][j], low_reg[k-1][j][QB-1]};
                low_nx[k][j] = low_reg[k-1][j] << 1;
                if (cur >= (ROOT_W+1)'(r_reg[k-1]))
                begin
                    rem_nx[k][j] = ROOT_W'(cur - (ROOT_W+1)'(r_reg[k-1]));
                    q_nx[k][j]   = {q_reg[k-1][j][QB-2:0], 1'b1};
                end
                else
                begin
                    rem_nx[k][j] = ROOT_W'(cur);
                    q_nx[k][j]   = {q_reg[k-1][j][QB-2:0], 1'b0};
                end
            end
            r_nx[k]    = r_reg[k-1];
            side_nx[k] = side_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < NS; k++)
        begin
            if (en[k])
            begin
                rem_reg[k]  <= rem_nx[k];
                low_reg[k]  <= low_nx[k];
                q_reg[k]    <= q_nx[k];
                r_reg[k]    <= r_nx[k];
                side_reg[k] <= side_nx[k];
            end
        end
    end

    assign q        = q_reg[NS-1];
    assign side_out = side_reg[NS-1];

endmodule

>>> design/pep_plane.sv
// Signed unit normal, dot product with the third point and rounded, saturated offset.
// Depends on pep_pkg.
module pep_plane
    import pep_pkg::*;
#(
    parameter int CB = COORD_BITS_DEF,
    parameter int F  = FRAC_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [F:0]            q [3],
    input  logic [2:0]            sgn,
    input  logic                  zero,
    input  logic signed [CB-1:0]  p3 [3],
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic signed [F+1:0]   n [3],
    output logic signed [F+9:0]   d,
    output logic                  degen
);

    localparam int NW  = F + 2;
    localparam int OW  = F + 10;
    localparam int PRW = NW + CB;
    localparam int TW  = PRW + 3;
    localparam int DDW = TW - PT_FRAC;
    localparam int SW  = (DDW > OW ? DDW : OW) + 1;
    localparam int NS  = 4;

    localparam logic [F:0] UNIT = (F+1)'(1) << F;
    localparam logic signed [TW-1:0] HALF = TW'(1) << (PT_FRAC - 1);
    localparam logic signed [SW-1:0] OMAX = {{(SW-OW+1){1'b0}}, {(OW-1){1'b1}}};
    localparam logic signed [SW-1:0] OMIN = {{(SW-OW+1){1'b1}}, {(OW-1){1'b0}}};

    logic [NS-1:0] v_reg;
    logic [NS:0]   en;

    logic signed [NW-1:0]  n_reg [NS][3];
    logic signed [CB-1:0]  p3_reg [3];
    logic signed [PRW-1:0] prod_reg [3];
    logic signed [TW-1:0]  t_reg;
    logic signed [OW-1:0]  d_reg;
    logic                  zero_reg [NS];

    logic [F:0]           qc [3];
    logic signed [NW-1:0] n_next [3];
    logic signed [SW-1:0] dx;
    logic signed [SW-1:0] dsat;

    always_comb
    begin
        en[NS] = out_ready;
        for (int k = NS - 1; k >= 0; k--)
        begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end

    assign in_ready  = en[0];
    assign out_valid = v_reg[NS-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                v_reg[0] <= in_valid;
            end
            for (int k = 1; k < NS; k++)
            begin
                if (en[k])
                begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    // A degenerate triangle forces a zero normal, which also makes the offset zero.
    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            qc[j] = (q[j] > UNIT) ? UNIT : q[j];
            if (zero)
            begin
                n_next[j] = '0;
            end
            else if (sgn[j])
            begin
                n_next[j] = -NW'(qc[j]);
            end
            else
            begin
                n_next[j] = NW'(qc[j]);
            end
        end
        dx = SW'(t_reg >>> PT_FRAC);
        if (dx > OMAX)
        begin
            dsat = OMAX;
        end
        else if (dx < OMIN)
        begin
            dsat = OMIN;
        end
        else
        begin
            dsat = dx;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            n_reg[0]    <= n_next;
            p3_reg      <= p3;
            zero_reg[0] <= zero;
        end
        if (en[1])
        begin
            for (int j = 0; j < 3; j++)
            begin
                prod_reg[j] <= n_reg[0][j] * p3_reg[j];
            end
            n_reg[1]    <= n_reg[0];
            zero_reg[1] <= zero_reg[0];
        end
        if (en[2])
        begin
            t_reg       <= HALF - prod_reg[0] - prod_reg[1] - prod_reg[2];
            n_reg[2]    <= n_reg[1];
            zero_reg[2] <= zero_reg[1];
        end
        if (en[3])
        begin
            d_reg       <= OW'(dsat);
            n_reg[3]    <= n_reg[2];
            zero_reg[3] <= zero_reg[2];
        end
    end

    assign n     = n_reg[NS-1];
    assign d     = d_reg;
    assign degen = zero_reg[NS-1];

endmodule

>>> bench/tb.sv
// Self-checking bench for plane_equation_from_points_top: random and directed triangles.
// Depends on pep_pkg and the design files; holds its own model of the plane arithmetic.
module tb;
    import pep_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC     = FRAC_BITS_DEF;
    localparam int LATENCY  = FRAC + 46;
    localparam int LIMIT    = 300000;
    localparam int HOLD_LEN = 3 * LATENCY + 200;

    typedef logic signed [COORD_BITS_DEF-1:0] coord_t;

    typedef struct {
        logic signed [FRAC+1:0] nx;
        logic signed [FRAC+1:0] ny;
        logic signed [FRAC+1:0] nz;
        logic signed [FRAC+9:0] offset;
        logic                   degen;
    } plane_t;

    logic   clk;
    logic   rst_n;
    logic   in_valid;
    logic   in_stall;
    coord_t p1_x, p1_y, p1_z, p2_x, p2_y, p2_z, p3_x, p3_y, p3_z;
    logic   out_valid;
    logic   out_stall;
    logic signed [FRAC+1:0] normal_x, normal_y, normal_z;
    logic signed [FRAC+9:0] plane_offset;
    logic   degenerate;

    plane_t pending_planes[$];
    int     errors = 0;
    int     cycles = 0;
    bit     tx_idle_en = 1;
    bit     rx_idle_en = 1;
    int     hold_left = 0;
    int     hold_req = 0;
    int     hold_seen = 0;

    plane_equation_from_points_top uut (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .p1_x(p1_x), .p1_y(p1_y), .p1_z(p1_z),
        .p2_x(p2_x), .p2_y(p2_y), .p2_z(p2_z),
        .p3_x(p3_x), .p3_y(p3_y), .p3_z(p3_z),
        .out_valid(out_valid), .out_stall(out_stall),
        .normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z),
        .plane_offset(plane_offset), .degenerate(degenerate)
    );

    initial
    begin
        clk = 0;
        forever #6 clk = ~clk;
    end

    function automatic bit [63:0] root64(input bit [63:0] val);
        bit [63:0] rem;
        bit [63:0] res;
        bit [63:0] b;
        rem = val;
        res = 0;
        b = 64'd1 << 62;
        while (b > rem)
            b >>= 2;
        while (b != 0)
        begin
            if (rem >= res + b)
            begin
                rem -= res + b;
                res = (res >> 1) + b;
            end
            else
                res >>= 1;
            b >>= 2;
        end
        return res;
    endfunction

    function automatic plane_t plane_of(input coord_t p[9]);
        longint    px[9];
        longint    u[3], v[3], c[3], nn[3];
        bit [63:0] m[3];
        bit [63:0] mx, sq, rt, q;
        longint    dot, dd;
        plane_t    r;
        for (int j = 0; j < 9; j++)
            px[j] = longint'(p[j]);
        for (int j = 0; j < 3; j++)
        begin
            u[j] = px[3+j] - px[j];
            v[j] = px[6+j] - px[j];
        end
        c[0] = u[1] * v[2] - v[1] * u[2];
        c[1] = v[0] * u[2] - u[0] * v[2];
        c[2] = u[0] * v[1] - v[0] * u[1];
        for (int j = 0; j < 3; j++)
            m[j] = c[j] < 0 ? -c[j] : c[j];
        mx = m[0];
        if (m[1] > mx) mx = m[1];
        if (m[2] > mx) mx = m[2];
        if (mx == 0)
        begin
            r = '{0, 0, 0, 0, 1'b1};
            return r;
        end
        // Bring the largest magnitude to [2^30, 2^31) with a common shift.
        while (mx >= (64'd1 << NORM_W))
        begin
            mx >>= 1;
            for (int j = 0; j < 3; j++) m[j] >>= 1;
        end
        while (mx < (64'd1 << (NORM_W - 1)))
        begin
            mx <<= 1;
            for (int j = 0; j < 3; j++) m[j] <<= 1;
        end
        sq = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
        rt = root64(sq);
        for (int j = 0; j < 3; j++)
        begin
            q = ((m[j] << FRAC) + (rt >> 1)) / rt;
            if (q > (64'd1 << FRAC)) q = 64'd1 << FRAC;
            nn[j] = c[j] < 0 ? -longint'(q) : longint'(q);
        end
        dot = nn[0] * px[6] + nn[1] * px[7] + nn[2] * px[8];
        dd = (-dot + (64'sd1 << (PT_FRAC - 1))) >>> PT_FRAC;
        if (dd > (64'sd1 << (FRAC + 9)) - 1) dd = (64'sd1 << (FRAC + 9)) - 1;
        if (dd < -(64'sd1 << (FRAC + 9))) dd = -(64'sd1 << (FRAC + 9));
        r.nx = (FRAC+2)'(nn[0]);
        r.ny = (FRAC+2)'(nn[1]);
        r.nz = (FRAC+2)'(nn[2]);
        r.offset = (FRAC+10)'(dd);
        r.degen = 1'b0;
        return r;
    endfunction

    task automatic send_tri(input coord_t p[9]);
        bit acc;
        while (tx_idle_en && $urandom_range(99) < 29)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        p1_x <= p[0]; p1_y <= p[1]; p1_z <= p[2];
        p2_x <= p[3]; p2_y <= p[4]; p2_z <= p[5];
        p3_x <= p[6]; p3_y <= p[7]; p3_z <= p[8];
        forever
        begin
            @(negedge clk);
            acc = !in_stall;
            @(posedge clk);
            if (acc) break;
        end
        pending_planes.push_back(plane_of(p));
    endtask

    function automatic coord_t rand_coord();
        int x;
        case ($urandom_range(3))
            0: x = $signed(16'($urandom));
            1: x = int'($urandom_range(1023)) - 512;
            2: x = $urandom_range(1) ? 32767 : -32768;
            default: x = int'($urandom_range(8191)) - 4096;
        endcase
        return coord_t'(x);
    endfunction

    // Mostly general triangles, with collinear and repeated-point cases mixed in.
    task automatic send_random_tri();
        coord_t p[9];
        int     a, d, k;
        case ($urandom_range(9))
            0:
            begin
                k = int'($urandom_range(5)) - 2;
                for (int j = 0; j < 3; j++)
                begin
                    a = int'($urandom_range(16000)) - 8000;
                    d = int'($urandom_range(8000)) - 4000;
                    p[j] = coord_t'(a);
                    p[3+j] = coord_t'(a + d);
                    p[6+j] = coord_t'(a + k * d);
                end
            end
            1:
            begin
                for (int j = 0; j < 9; j++)
                    p[j] = rand_coord();
                for (int j = 0; j < 3; j++)
                    p[3+j] = p[j];
            end
            default:
                for (int j = 0; j < 9; j++)
                    p[j] = rand_coord();
        endcase
        send_tri(p);
    endtask

    // Receiver: random stalls, or a solid hold-off while hold_left counts down.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (hold_req != hold_seen)
        begin
            hold_seen <= hold_req;
            hold_left <= HOLD_LEN;
            out_stall <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else
            out_stall <= rx_idle_en && ($urandom_range(99) < 29);
    end

    initial
    begin
        wait (cycles > LIMIT);
        $display("tb: failure");
        $finish;
    end

    // Result checker: sampled at the falling edge, accepted at the next rising edge.
    initial
    begin
        plane_t want;
        forever
        begin
            @(negedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                if (pending_planes.size() == 0)
                begin
                    $error("unexpected result transaction");
                    errors++;
                end
                else
                begin
                    want = pending_planes.pop_front();
                    if (normal_x !== want.nx)
                    begin
                        $error("normal_x expected %0d actual %0d", want.nx, normal_x);
                        errors++;
                    end
                    if (normal_y !== want.ny)
                    begin
                        $error("normal_y expected %0d actual %0d", want.ny, normal_y);
                        errors++;
                    end
                    if (normal_z !== want.nz)
                    begin
                        $error("normal_z expected %0d actual %0d", want.nz, normal_z);
                        errors++;
                    end
                    if (plane_offset !== want.offset)
                    begin
                        $error("plane_offset expected %0d actual %0d",
                               want.offset, plane_offset);
                        errors++;
                    end
                    if (degenerate !== want.degen)
                    begin
                        $error("degenerate expected %0d actual %0d", want.degen, degenerate);
                        errors++;
                    end
                end
            end
        end
    end

    task automatic test_directed();
        send_tri('{0, 0, 0, 0, 0, 0, 0, 0, 0});
        send_tri('{0, 0, 0, 256, 0, 0, 0, 256, 0});
        send_tri('{0, 0, 0, 0, 256, 0, 256, 0, 0});
        send_tri('{0, 0, 0, 1, 0, 0, 0, 1, 0});
        send_tri('{32767, 0, 0, 32767, 256, 0, 32767, 0, 256});
        send_tri('{-32768, 0, 0, -32768, 0, 256, -32768, 256, 0});
        send_tri('{-32768, -32768, -32768, 32767, -32768, -32768, -32768, 32767, 32767});
        send_tri('{32767, 32767, 32767, -32768, 32767, -32768, 32767, -32768, -32768});
        send_tri('{-32768, -32768, 0, 32767, -32768, 0, -32768, 32767, 32767});
        send_tri('{0, 0, 0, 100, 200, 300, 200, 400, 600});
        send_tri('{1234, -5, 77, 1234, -5, 77, 1234, -5, 77});
        send_tri('{-32768, -32768, -32768, 32767, 32767, 32767, -1, -1, -1});
        send_tri('{256, 0, 0, 0, 256, 0, 0, 0, 256});
        send_tri('{-256, 0, 0, 0, -256, 0, 0, 0, -256});
        send_tri('{32767, 32767, 32767, -32768, 32767, 32767, 32767, -32768, 32767});
        send_tri('{5, -7, 3, 5, -7, 3, 900, 12, -40});
        send_tri('{-1, -1, -1, 1, 2, 3, 7, -3, 32767});
    endtask

    task automatic test_random(input int count);
        repeat (count) send_random_tri();
    endtask

    task automatic test_no_idle(input int count);
        tx_idle_en = 0;
        rx_idle_en = 0;
        repeat (count) send_random_tri();
        tx_idle_en = 1;
        rx_idle_en = 1;
    endtask

    // Long output hold-off with the sender streaming, so the pipeline fills and stalls.
    task automatic test_backpressure(input int count);
        tx_idle_en = 0;
        hold_req++;
        repeat (count) send_random_tri();
        tx_idle_en = 1;
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        {p1_x, p1_y, p1_z, p2_x, p2_y, p2_z, p3_x, p3_y, p3_z} = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(400);
        test_no_idle(120);
        test_backpressure(150);
        test_random(280);
        in_valid <= 1'b0;
        wait (pending_planes.size() == 0);
        repeat (LATENCY + 20) @(posedge clk);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

>>> plane_equation_from_points_top.f
design/pep_pkg.sv
design/pep_cross.sv
design/pep_norm.sv
design/pep_sqrt.sv
design/pep_div.sv
design/pep_plane.sv
design/plane_equation_from_points_top.sv
bench/tb.sv
